[rtl/assert_macros.svh]
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/cdq_pkg.sv]
`default_nettype none
package cdq_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W     = 8;
  localparam int CAP_RESET = 128;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage
`default_nettype wire

[rtl/cdq_intf.sv]
`default_nettype none
interface cdq_req_if #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::MODE_W-1:0]    mode;
  logic signed [DATA_WIDTH-1:0]  data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink (input valid, input mode, input data_in, output ready);
endinterface

interface cdq_rsp_if #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [DATA_WIDTH-1:0]   data_out;
  logic [cdq_pkg::STATUS_W-1:0]   status;
  logic                           is_empty;
  logic                           is_full;

  modport source (output valid, output data_out, output status, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input data_out, input status, input is_empty,
                input is_full, output ready);
endinterface

interface cdq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::CAP_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/circular_deque.sv]
// an accepted word passes the s1 stage and then the output register before its result is valid
// no new word is accepted while one sits in the s1 stage, where the storage ram read is held
//   before the result register loads; a stalled result holds off the next word
// reset: deque empty, both pointers 0, capacity 128 (clipped to DEPTH)
// storage contents are not cleared; a capacity write also empties the deque
`default_nettype none
module circular_deque #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cdq_req_if.sink      req_i,
  cdq_rsp_if.source    rsp_o,
  cdq_cfg_if.sink      cfg_i
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;
  localparam int SLOTS_RST = (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                               input logic [SW-1:0] slots);
    logic [SW-1:0] n;
    n = SW'(p) + SW'(1);
    return (n >= slots) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                 input logic [SW-1:0] slots);
    logic [SW-1:0] last;
    last = slots - SW'(1);
    return (p == '0) ? last[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

  logic [DATA_WIDTH-1:0] storage_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic [SW-1:0]    slots_q, slots_d;
  logic [PTR_W-1:0] front_q, front_d, rear_q, rear_d;
  logic             empty_q, empty_d;

  logic                          s1_valid_q;
  logic                          s1_pop_ok_q, pop_ok;
  logic [cdq_pkg::STATUS_W-1:0]  s1_status_q, status_d;
  logic                          s1_empty_q, s1_full_q, full_d;

  logic                          out_valid_q;
  logic [DATA_WIDTH-1:0]         out_data_q;
  logic [cdq_pkg::STATUS_W-1:0]  out_status_q;
  logic                          out_empty_q, out_full_q;

  logic                 accept, is_push, full_now;
  logic                 mem_we, mem_re;
  logic [PTR_W-1:0]     mem_addr;
  logic [SW-1:0]        cap_ext;

  assign req_i.ready = !s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  assign is_push  = (req_i.mode == cdq_pkg::MODE_PUSH_REAR) ||
                    (req_i.mode == cdq_pkg::MODE_PUSH_FRONT);
  assign full_now = !empty_q && (step_up(rear_q, slots_q) == front_q);
  assign cap_ext  = SW'(cfg_i.data);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    slots_d  = slots_q;
    status_d = cdq_pkg::STATUS_DONE;
    pop_ok   = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;
    if (cfg_i.valid) begin
      if (cap_ext == '0) begin
        slots_d = SW'(1);
      end else if (cap_ext > SW'(DEPTH)) begin
        slots_d = SW'(DEPTH);
      end else begin
        slots_d = cap_ext;
      end
      front_d = '0;
      rear_d  = '0;
      empty_d = 1'b1;
    end else if (accept) begin
      if (is_push) begin
        if (full_now) begin
          status_d = cdq_pkg::STATUS_OVERFLOW;
        end else if (empty_q) begin
          front_d  = '0;
          rear_d   = '0;
          empty_d  = 1'b0;
          mem_we   = 1'b1;
          mem_addr = '0;
        end else if (req_i.mode == cdq_pkg::MODE_PUSH_REAR) begin
          rear_d   = step_up(rear_q, slots_q);
          mem_we   = 1'b1;
          mem_addr = rear_d;
        end else begin
          front_d  = step_down(front_q, slots_q);
          mem_we   = 1'b1;
          mem_addr = front_d;
        end
      end else begin
        if (empty_q) begin
          status_d = cdq_pkg::STATUS_UNDERFLOW;
        end else begin
          pop_ok = 1'b1;
          mem_re = 1'b1;
          if (front_q == rear_q) begin
            // last element leaves
            mem_addr = front_q;
            front_d  = '0;
            rear_d   = '0;
            empty_d  = 1'b1;
          end else if (req_i.mode == cdq_pkg::MODE_POP_FRONT) begin
            mem_addr = front_q;
            front_d  = step_up(front_q, slots_q);
          end else begin
            mem_addr = rear_q;
            rear_d   = step_down(rear_q, slots_q);
          end
        end
      end
    end
    full_d = !empty_d && (step_up(rear_d, slots_q) == front_d);
  end

  // storage ram, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      storage_q[mem_addr] <= req_i.data_in;
    end
    if (mem_re) begin
      rd_data_q <= storage_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= SW'(SLOTS_RST);
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slots_q    <= slots_d;
      front_q    <= front_d;
      rear_q     <= rear_d;
      empty_q    <= empty_d;
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_ok_q <= pop_ok;
      s1_status_q <= status_d;
      s1_empty_q  <= empty_d;
      s1_full_q   <= full_d;
    end
    if (s1_valid_q) begin
      out_data_q   <= s1_pop_ok_q ? rd_data_q : '0;
      out_status_q <= s1_status_q;
      out_empty_q  <= s1_empty_q;
      out_full_q   <= s1_full_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.is_empty = out_empty_q;
  assign rsp_o.is_full  = out_full_q;

endmodule
`default_nettype wire

[rtl/circular_deque_chk.sv]
`default_nettype none
`include "assert_macros.svh"
module circular_deque_chk #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [DATA_WIDTH-1:0]         data_out_i,
  input wire logic [cdq_pkg::STATUS_W-1:0]  status_i,
  input wire logic                          is_empty_i,
  input wire logic                          is_full_i
);

  // a stalled result word holds
  `ASSERT_NEXT(rsp_hold_a, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(data_out_i))

  // deque cannot be empty and full at once
  `ASSERT_SAME(empty_full_a, rsp_valid_i, !(is_empty_i && is_full_i))

  // underflow leaves an empty deque and returns zero
  `ASSERT_SAME(underflow_a, rsp_valid_i && (status_i == cdq_pkg::STATUS_UNDERFLOW),
               is_empty_i && (data_out_i == '0))

  // overflow leaves a full deque and returns zero
  `ASSERT_SAME(overflow_a, rsp_valid_i && (status_i == cdq_pkg::STATUS_OVERFLOW),
               is_full_i && (data_out_i == '0))

endmodule

bind circular_deque circular_deque_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .data_out_i  (rsp_o.data_out),
  .status_i    (rsp_o.status),
  .is_empty_i  (rsp_o.is_empty),
  .is_full_i   (rsp_o.is_full)
);
`default_nettype wire

[sim/deque_result_checker.sv]
`timescale 1ns / 100ps
module deque_result_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cdq_req_if         req_i,
  cdq_rsp_if         rsp_i,
  cdq_cfg_if         cfg_i,
  output int unsigned outstanding_o,
  output int unsigned err_count_o
);

  localparam int unsigned Depth = cdq_pkg::DEPTH_DEF;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [cdq_pkg::DATA_WIDTH_DEF-1:0] data_out;
    logic [cdq_pkg::STATUS_W-1:0]       status;
    logic                               is_empty;
    logic                               is_full;
  } deque_result_t;

  deque_result_t expected_results[$];
  logic [cdq_pkg::DATA_WIDTH_DEF-1:0] slot_words [Depth];
  int unsigned front_ptr;
  int unsigned rear_ptr;
  bit          deque_empty;
  logic [cdq_pkg::CAP_W-1:0] cap_reg;
  int unsigned err_count;

  // zero behaves as one slot, anything above the store size is clipped
  function automatic int unsigned live_slots();
    if (cap_reg == 0) return 1;
    if (32'(cap_reg) > Depth) return Depth;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned ptr_up(int unsigned p);
    int unsigned n;
    n = p + 1;
    return (n >= live_slots()) ? 0 : n;
  endfunction

  function automatic int unsigned ptr_down(int unsigned p);
    int unsigned c;
    c = live_slots();
    if (p == 0 || p >= c) return c - 1;
    return p - 1;
  endfunction

  function automatic bit at_capacity();
    return !deque_empty && ptr_up(rear_ptr) == front_ptr;
  endfunction

  function automatic deque_result_t deque_apply(logic [cdq_pkg::MODE_W-1:0] op,
                                                logic [cdq_pkg::DATA_WIDTH_DEF-1:0] word);
    deque_result_t r;
    r = '0;
    r.status = cdq_pkg::STATUS_DONE;
    if (op == cdq_pkg::MODE_PUSH_REAR || op == cdq_pkg::MODE_PUSH_FRONT) begin
      if (at_capacity()) begin
        r.status = cdq_pkg::STATUS_OVERFLOW;
      end else if (deque_empty) begin
        front_ptr = 0;
        rear_ptr = 0;
        deque_empty = 1'b0;
        slot_words[0] = word;
      end else if (op == cdq_pkg::MODE_PUSH_REAR) begin
        rear_ptr = ptr_up(rear_ptr);
        slot_words[rear_ptr] = word;
      end else begin
        front_ptr = ptr_down(front_ptr);
        slot_words[front_ptr] = word;
      end
    end else begin
      if (deque_empty) begin
        r.status = cdq_pkg::STATUS_UNDERFLOW;
      end else if (front_ptr == rear_ptr) begin
        // last element leaves, pointers go home
        r.data_out = slot_words[front_ptr];
        deque_empty = 1'b1;
        front_ptr = 0;
        rear_ptr = 0;
      end else if (op == cdq_pkg::MODE_POP_FRONT) begin
        r.data_out = slot_words[front_ptr];
        front_ptr = ptr_up(front_ptr);
      end else begin
        r.data_out = slot_words[rear_ptr];
        rear_ptr = ptr_down(rear_ptr);
      end
    end
    r.is_empty = deque_empty;
    r.is_full = at_capacity();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      front_ptr = 0;
      rear_ptr = 0;
      deque_empty = 1'b1;
      cap_reg = cdq_pkg::CAP_W'(cdq_pkg::CAP_RESET);
      err_count = 0;
      outstanding_o <= 0;
      err_count_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.data_out = rsp_i.data_out;
        got.status = rsp_i.status;
        got.is_empty = rsp_i.is_empty;
        got.is_full = rsp_i.is_full;
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= ReportMax)
            $display("unexpected result word: data_out %h status %0d empty %b full %b",
                     got.data_out, got.status, got.is_empty, got.is_full);
        end else begin
          want = expected_results.pop_front();
          if (got.data_out !== want.data_out || got.status !== want.status ||
              got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
            err_count++;
            if (err_count <= ReportMax)
              $display("result mismatch: exp data_out %h status %0d empty %b full %b, %s",
                       want.data_out, want.status, want.is_empty, want.is_full,
                       $sformatf("got data_out %h status %0d empty %b full %b",
                                 got.data_out, got.status, got.is_empty, got.is_full));
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        // capacity write also empties the deque
        cap_reg = cfg_i.data;
        deque_empty = 1'b1;
        front_ptr = 0;
        rear_ptr = 0;
      end
      if (req_i.valid && req_i.ready)
        expected_results.push_back(deque_apply(req_i.mode, req_i.data_in));
      outstanding_o <= expected_results.size();
      err_count_o <= err_count;
    end
  end

endmodule

[sim/tb_circular_deque.sv]
`timescale 1ns / 100ps
module tb_circular_deque;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned MixLen = 45;

  logic clk_i;
  logic rst_ni;

  cdq_req_if req ();
  cdq_rsp_if rsp ();
  cdq_cfg_if cfg ();

  int unsigned outstanding;
  int unsigned err_count;
  bit          no_idle;

  circular_deque i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  deque_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rsp_i         (rsp),
    .cfg_i         (cfg),
    .outstanding_o (outstanding),
    .err_count_o   (err_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_circular_deque: errors");
    $finish;
  end

  // result side: random stall before each word, ready held while no stall
  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    stall = no_idle ? 0 : $urandom_range(0, 19);
    forever begin
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
      stall = no_idle ? 0 : $urandom_range(0, 19);
    end
  end

  function automatic logic [cdq_pkg::DATA_WIDTH_DEF-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [cdq_pkg::MODE_W-1:0] op,
                           input logic [cdq_pkg::DATA_WIDTH_DEF-1:0] word);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= op;
    req.data_in <= word;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= cap;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [cdq_pkg::CAP_W-1:0] cap;
    int unsigned slots;
    rst_ni <= 1'b0;
    no_idle = 1'b0;
    req.valid <= 1'b0;
    req.mode <= cdq_pkg::MODE_PUSH_REAR;
    req.data_in <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty after reset, then extremes in and out of both ends
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());
    send_word(cdq_pkg::MODE_POP_REAR, random_word());
    send_word(cdq_pkg::MODE_PUSH_REAR, 32'h7fff_ffff);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
    send_word(cdq_pkg::MODE_PUSH_REAR, 32'h0000_0000);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff);
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());
    send_word(cdq_pkg::MODE_POP_REAR, random_word());
    send_word(cdq_pkg::MODE_POP_REAR, random_word());
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());

    // zero capacity acts as a single slot
    write_capacity('0);
    send_word(cdq_pkg::MODE_PUSH_REAR, 32'h5a5a_5a5a);
    send_word(cdq_pkg::MODE_PUSH_FRONT, random_word());
    send_word(cdq_pkg::MODE_PUSH_REAR, random_word());
    send_word(cdq_pkg::MODE_POP_REAR, random_word());

    write_capacity(8'd2);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'ha5a5_a5a5);
    send_word(cdq_pkg::MODE_PUSH_FRONT, 32'h1234_5678);
    send_word(cdq_pkg::MODE_PUSH_REAR, random_word());
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());

    // capacity write while holding a word empties the deque
    send_word(cdq_pkg::MODE_PUSH_REAR, random_word());
    write_capacity(8'd3);
    send_word(cdq_pkg::MODE_POP_REAR, random_word());
    send_word(cdq_pkg::MODE_POP_FRONT, random_word());

    for (int i = 0; i < 14; i++) begin
      case (i)
        0: cap = 8'd1;
        1: cap = 8'd2;
        2: cap = 8'd128;
        3: cap = 8'd0;
        4: cap = 8'd255;
        5: cap = cdq_pkg::CAP_W'($urandom_range(129, 254));
        6: cap = cdq_pkg::CAP_W'($urandom_range(41, 128));
        default: cap = cdq_pkg::CAP_W'($urandom_range(1, 40));
      endcase
      write_capacity(cap);
      no_idle = (i % 4 == 3);
      slots = (cap == 0) ? 1 :
              (32'(cap) > cdq_pkg::DEPTH_DEF) ? cdq_pkg::DEPTH_DEF : 32'(cap);
      // fill past full, mix, then drain past empty
      repeat (slots + 2) send_word(cdq_pkg::MODE_W'($urandom_range(0, 1)), random_word());
      repeat (MixLen) send_word(cdq_pkg::MODE_W'($urandom_range(0, 3)), random_word());
      repeat (slots + 2) send_word(cdq_pkg::MODE_W'($urandom_range(2, 3)), random_word());
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_circular_deque: clean");
    end else begin
      $display("tb_circular_deque: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_intf.sv
rtl/circular_deque.sv
rtl/circular_deque_chk.sv
sim/deque_result_checker.sv
sim/tb_circular_deque.sv
